/* rtl/assert_macros.svh */
// assertion macros used by the lexer rtl
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk_i, rstn_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk_i, rstn_i, prop, msg)
`define ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg)

`endif

`endif

/* rtl/csstok_pkg.sv */
// token kind codes, character codes and character class helpers
// for the css token boundary lexer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package csstok_pkg;

  typedef logic [4:0] kind_t;
  typedef logic [7:0] char_t;

  // token kinds
  localparam kind_t KIND_AT      = 5'd0;
  localparam kind_t KIND_HASH    = 5'd1;
  localparam kind_t KIND_NUM     = 5'd2;
  localparam kind_t KIND_PCT     = 5'd3;
  localparam kind_t KIND_IDENT   = 5'd4;
  localparam kind_t KIND_MINUS   = 5'd5;
  localparam kind_t KIND_COMMENT = 5'd6;
  localparam kind_t KIND_DIV     = 5'd7;
  localparam kind_t KIND_SEMI    = 5'd8;
  localparam kind_t KIND_COLON   = 5'd9;
  localparam kind_t KIND_LBRACE  = 5'd10;
  localparam kind_t KIND_RBRACE  = 5'd11;
  localparam kind_t KIND_LPAREN  = 5'd12;
  localparam kind_t KIND_RPAREN  = 5'd13;
  localparam kind_t KIND_LBRACK  = 5'd14;
  localparam kind_t KIND_RBRACK  = 5'd15;
  localparam kind_t KIND_DOT     = 5'd16;
  localparam kind_t KIND_MUL     = 5'd17;
  localparam kind_t KIND_ADD     = 5'd18;
  localparam kind_t KIND_STRING  = 5'd19;
  localparam kind_t KIND_OTHER   = 5'd20;
  localparam kind_t KIND_END     = 5'd21;

  // character codes
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_FF     = 8'h0C;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_AT     = 8'h40;
  localparam char_t CH_HASH   = 8'h23;
  localparam char_t CH_PCT    = 8'h25;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_UNDER  = 8'h5F;
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_DQUOTE = 8'h22;
  localparam char_t CH_SQUOTE = 8'h27;
  localparam char_t CH_SEMI   = 8'h3B;
  localparam char_t CH_COLON  = 8'h3A;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_LBRACK = 8'h5B;
  localparam char_t CH_RBRACK = 8'h5D;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_DIG0   = 8'h30;
  localparam char_t CH_DIG9   = 8'h39;
  localparam char_t CH_LA     = 8'h61;
  localparam char_t CH_LZ     = 8'h7A;
  localparam char_t CH_UA     = 8'h41;
  localparam char_t CH_UZ     = 8'h5A;

  // letter or underscore
  function automatic logic is_alpha_us(input char_t c);
    return (c == CH_UNDER) || (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= CH_DIG0) && (c <= CH_DIG9);
  endfunction

  function automatic logic is_name_char(input char_t c);
    return is_alpha_us(c) || is_digit(c) || (c == CH_MINUS);
  endfunction

endpackage

`default_nettype wire

/* rtl/css_token_boundary_lexer.sv */
// A closed token is written into the result queue, whose head is offered on out_*.
// Throughput: one byte per cycle while in_tready is high; a request that closes two tokens
// (or the end mark with a pending token) puts two entries into the four-deep queue, which
// drains one a cycle while out_tready is high; in_tready holds while two entries are free.
// Reset: synchronous active-low rst_n clears the lexer state, the byte offset and the queue.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module css_token_boundary_lexer #(
  parameter int LENGTH_WIDTH = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // input byte stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] character
  input  wire logic       in_tlast,   // end_of_input
  // token stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  // [OFFSET_WIDTH-1:0] start_offset, then token_length, zero padded to whole bytes
  output logic [((OFFSET_WIDTH + LENGTH_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  output logic [4:0]      out_tuser,  // [4:0] token_kind
  output logic            out_tlast   // last_of_run
);

  import csstok_pkg::*;

  localparam int                 QDEPTH  = 4;
  localparam int                 QPTR_W  = $clog2(QDEPTH);
  localparam int                 QCNT_W  = $clog2(QDEPTH + 1);
  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

  typedef enum logic [4:0] {
    MODE_IDLE, MODE_AT0, MODE_AT1, MODE_HASH0, MODE_NAME, MODE_MINUS0, MODE_MINUS1,
    MODE_DOT0, MODE_DOT1, MODE_SLASH, MODE_LINE, MODE_BLOCK, MODE_BLOCK_STAR,
    MODE_STRING, MODE_INT, MODE_INT_NODEC, MODE_FRAC
  } mode_t;

  typedef struct packed {
    kind_t                   kind;
    logic [OFFSET_WIDTH-1:0] start;
    logic [LENGTH_WIDTH-1:0] len;
    logic                    last;
  } res_t;

  // lexer state
  mode_t                   mode_r, mode_nxt;
  kind_t                   kind_r, kind_nxt;
  logic [OFFSET_WIDTH-1:0] start_r, start_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  char_t                   quote_r, quote_nxt;
  logic [OFFSET_WIDTH-1:0] pos_r, pos_nxt;

  // result queue
  res_t                    q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]       q_wr_r, q_rd_r;
  logic [QCNT_W-1:0]       q_cnt_r;

  logic                    in_fire, out_fire;
  char_t                   c;
  logic                    absorbed;
  logic [LENGTH_WIDTH-1:0] len_grown;
  res_t                    res_a, res_b, push0, push1;
  logic [1:0]              n_push;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign c        = in_tdata;
  assign len_grown = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;

  // one request: extend or close the pending token, maybe start one, or flush at the end
  always_comb begin
    mode_nxt  = mode_r;
    kind_nxt  = kind_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    quote_nxt = quote_r;
    pos_nxt   = pos_r;
    res_a     = '0;
    res_b     = '0;
    absorbed  = 1'b0;
    if (in_tlast) begin
      // flush whatever is pending, then the end token
      res_a.start = start_r;
      res_a.len   = len_r;
      res_a.last  = 1'b1;
      unique case (mode_r) inside
        MODE_IDLE, MODE_LINE: res_a.last = 1'b0;
        MODE_NAME, MODE_INT, MODE_INT_NODEC, MODE_FRAC: res_a.kind = kind_r;
        MODE_MINUS0, MODE_MINUS1: res_a.kind = KIND_MINUS;
        MODE_DOT0: res_a.kind = KIND_DOT;
        MODE_SLASH: res_a.kind = KIND_DIV;
        default: res_a.kind = KIND_OTHER;
      endcase
      res_b.kind  = KIND_END;
      res_b.start = pos_r;
      res_b.len   = '0;
      res_b.last  = 1'b1;
      mode_nxt  = MODE_IDLE;
      kind_nxt  = '0;
      start_nxt = '0;
      len_nxt   = '0;
      quote_nxt = '0;
      pos_nxt   = '0;
    end else begin
      // extend the pending token or close it
      res_a.start = start_r;
      res_a.len   = len_r;
      unique case (mode_r)
        MODE_AT0: begin
          if (c == CH_MINUS) begin
            absorbed = 1'b1; len_nxt = len_grown; mode_nxt = MODE_AT1;
          end else if (is_alpha_us(c)) begin
            absorbed = 1'b1; len_nxt = len_grown; mode_nxt = MODE_NAME;
          end else begin
            res_a.last = 1'b1; res_a.kind = KIND_OTHER; mode_nxt = MODE_IDLE;
          end
        end
        MODE_AT1, MODE_DOT1: begin
          if (is_alpha_us(c) || c == CH_MINUS) begin
            absorbed = 1'b1; len_nxt = len_grown; mode_nxt = MODE_NAME;
          end else begin
            res_a.last = 1'b1; res_a.kind = KIND_OTHER; mode_nxt = MODE_IDLE;
          end
        end
        MODE_HASH0: begin
          if (is_name_char(c)) begin
            absorbed = 1'b1; len_nxt = len_grown; mode_nxt = MODE_NAME;
          end else begin
            res_a.last = 1'b1; res_a.kind = KIND_OTHER; mode_nxt = MODE_IDLE;
          end
        end
        MODE_NAME: begin
          if (is_name_char(c)) begin
            absorbed = 1'b1; len_nxt = len_grown;
          end else begin
            res_a.last = 1'b1; res_a.kind = kind_r; mode_nxt = MODE_IDLE;
          end
        end
        MODE_MINUS0: begin
          if (is_digit(c)) begin
            absorbed = 1'b1; len_nxt = len_grown; kind_nxt = KIND_NUM; mode_nxt = MODE_INT;
          end else if (c == CH_MINUS) begin
            absorbed = 1'b1; len_nxt = len_grown; mode_nxt = MODE_MINUS1;
          end else if (is_alpha_us(c)) begin
            absorbed = 1'b1; len_nxt = len_grown; kind_nxt = KIND_IDENT;
            mode_nxt = MODE_NAME;
          end else begin
            res_a.last = 1'b1; res_a.kind = KIND_MINUS; mode_nxt = MODE_IDLE;
          end
        end
        MODE_MINUS1: begin
          if (is_alpha_us(c) || c == CH_MINUS) begin
            absorbed = 1'b1; len_nxt = len_grown; kind_nxt = KIND_IDENT;
            mode_nxt = MODE_NAME;
          end else begin
            res_a.last = 1'b1; res_a.kind = KIND_MINUS; mode_nxt = MODE_IDLE;
          end
        end
        MODE_DOT0: begin
          if (is_digit(c)) begin
            absorbed = 1'b1; len_nxt = len_grown; kind_nxt = KIND_NUM;
            mode_nxt = MODE_INT_NODEC;
          end else if (c == CH_MINUS) begin
            absorbed = 1'b1; len_nxt = len_grown; mode_nxt = MODE_DOT1;
          end else if (is_alpha_us(c)) begin
            absorbed = 1'b1; len_nxt = len_grown; mode_nxt = MODE_NAME;
          end else begin
            res_a.last = 1'b1; res_a.kind = KIND_DOT; mode_nxt = MODE_IDLE;
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            absorbed = 1'b1; mode_nxt = MODE_LINE;
          end else if (c == CH_STAR) begin
            absorbed = 1'b1; len_nxt = len_grown; kind_nxt = KIND_COMMENT;
            mode_nxt = MODE_BLOCK;
          end else begin
            res_a.last = 1'b1; res_a.kind = KIND_DIV; mode_nxt = MODE_IDLE;
          end
        end
        MODE_LINE: begin
          // line comment ends silently at the line feed, which is then whitespace
          if (c == CH_LF) mode_nxt = MODE_IDLE;
          else absorbed = 1'b1;
        end
        MODE_BLOCK: begin
          absorbed = 1'b1; len_nxt = len_grown;
          if (c == CH_STAR) mode_nxt = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          absorbed = 1'b1; len_nxt = len_grown;
          if (c == CH_SLASH) begin
            res_a.last = 1'b1; res_a.kind = KIND_COMMENT; res_a.len = len_grown;
            mode_nxt = MODE_IDLE;
          end else if (c != CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end
        end
        MODE_STRING: begin
          absorbed = 1'b1; len_nxt = len_grown;
          if (c == quote_r) begin
            res_a.last = 1'b1; res_a.kind = KIND_STRING; res_a.len = len_grown;
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_INT, MODE_INT_NODEC, MODE_FRAC: begin
          if (is_digit(c)) begin
            absorbed = 1'b1; len_nxt = len_grown;
          end else if (c == CH_PCT) begin
            absorbed = 1'b1; len_nxt = len_grown;
            res_a.last = 1'b1; res_a.kind = KIND_PCT; res_a.len = len_grown;
            mode_nxt = MODE_IDLE;
          end else if (c == CH_DOT && mode_r == MODE_INT) begin
            absorbed = 1'b1; len_nxt = len_grown; mode_nxt = MODE_FRAC;
          end else begin
            res_a.last = 1'b1; res_a.kind = KIND_NUM; mode_nxt = MODE_IDLE;
          end
        end
        default: mode_nxt = MODE_IDLE;
      endcase

      // start a new token with a byte that was not absorbed
      if (!absorbed) begin
        res_b.start = pos_r;
        res_b.len   = {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
        res_b.last  = 1'b1;
        unique case (c) inside
          CH_SPACE, CH_TAB, CH_CR, CH_FF, CH_LF: res_b.last = 1'b0;
          CH_AT: begin
            res_b.last = 1'b0; kind_nxt = KIND_AT; mode_nxt = MODE_AT0;
          end
          CH_HASH: begin
            res_b.last = 1'b0; kind_nxt = KIND_HASH; mode_nxt = MODE_HASH0;
          end
          CH_MINUS: begin
            res_b.last = 1'b0; kind_nxt = KIND_MINUS; mode_nxt = MODE_MINUS0;
          end
          CH_SLASH: begin
            res_b.last = 1'b0; kind_nxt = KIND_DIV; mode_nxt = MODE_SLASH;
          end
          CH_DOT: begin
            res_b.last = 1'b0; kind_nxt = KIND_DOT; mode_nxt = MODE_DOT0;
          end
          CH_DQUOTE, CH_SQUOTE: begin
            res_b.last = 1'b0; kind_nxt = KIND_STRING; mode_nxt = MODE_STRING;
            quote_nxt = c;
          end
          CH_SEMI:   res_b.kind = KIND_SEMI;
          CH_COLON:  res_b.kind = KIND_COLON;
          CH_LBRACE: res_b.kind = KIND_LBRACE;
          CH_RBRACE: res_b.kind = KIND_RBRACE;
          CH_LPAREN: res_b.kind = KIND_LPAREN;
          CH_RPAREN: res_b.kind = KIND_RPAREN;
          CH_LBRACK: res_b.kind = KIND_LBRACK;
          CH_RBRACK: res_b.kind = KIND_RBRACK;
          CH_STAR:   res_b.kind = KIND_MUL;
          CH_PLUS:   res_b.kind = KIND_ADD;
          default: begin
            if (is_digit(c)) begin
              res_b.last = 1'b0; kind_nxt = KIND_NUM; mode_nxt = MODE_INT;
            end else if (is_alpha_us(c)) begin
              res_b.last = 1'b0; kind_nxt = KIND_IDENT; mode_nxt = MODE_NAME;
            end else begin
              res_b.kind = KIND_OTHER;
            end
          end
        endcase
        // a multi-byte token begins here
        if (mode_nxt != MODE_IDLE) begin
          start_nxt = pos_r;
          len_nxt   = {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
        end
      end
      pos_nxt = pos_r + 1'b1;
    end
  end

  // order the results of this request; the valid mark rides in the last bit until here
  always_comb begin
    push0 = res_a.last ? res_a : res_b;
    push1 = res_b;
    push0.last = !(res_a.last && res_b.last);
    push1.last = 1'b1;
    n_push = {1'b0, res_a.last} + {1'b0, res_b.last};
  end

  // lexer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      kind_r  <= '0;
      start_r <= '0;
      len_r   <= '0;
      quote_r <= '0;
      pos_r   <= '0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      kind_r  <= kind_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      quote_r <= quote_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (in_fire && n_push != 2'd0) q_mem_r[q_wr_r] <= push0;
    if (in_fire && n_push == 2'd2) q_mem_r[q_wr_r + 1'b1] <= push1;
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (in_fire) q_wr_r <= q_wr_r + QPTR_W'(n_push);
      if (out_fire) q_rd_r <= q_rd_r + 1'b1;
      q_cnt_r <= q_cnt_r + (in_fire ? QCNT_W'(n_push) : '0) - QCNT_W'(out_fire);
    end
  end

  assign in_tready  = (q_cnt_r <= QCNT_W'(QDEPTH - 2));
  assign out_tvalid = (q_cnt_r != '0);

  // output payload from the queue head
  always_comb begin
    out_tdata = '0;
    out_tdata[OFFSET_WIDTH-1:0] = q_mem_r[q_rd_r].start;
    out_tdata[OFFSET_WIDTH +: LENGTH_WIDTH] = q_mem_r[q_rd_r].len;
    out_tuser = q_mem_r[q_rd_r].kind;
    out_tlast = q_mem_r[q_rd_r].last;
  end

  // checks
  `ASSERT_NEVER(a_q_overflow, clk, rst_n, q_cnt_r > QCNT_W'(QDEPTH), "result queue overflow")
  `ASSERT_ALWAYS(a_end_restarts, clk, rst_n, (in_fire && in_tlast) |=> (mode_r == MODE_IDLE && pos_r == '0), "end mark did not restart the lexer")
  `ASSERT_ALWAYS(a_end_pushes, clk, rst_n, (in_fire && in_tlast) |-> (n_push != 2'd0 && push0.kind == (n_push == 2'd1 ? KIND_END : push0.kind)), "end mark produced no end token")

endmodule

`default_nettype wire

/* sim/tb_css_token_boundary_lexer.sv */
// self-checking bench for css_token_boundary_lexer: byte requests in, token results out
// depends on csstok_pkg and the lexer rtl; tokens are predicted by a shadow lexer class
`timescale 1ns / 1ps

module tb_css_token_boundary_lexer;
  import csstok_pkg::*;

  localparam int OFF_W = 32;
  localparam int LEN_W = 16;
  localparam int DATA_W = ((OFF_W + LEN_W + 7) / 8) * 8;
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  typedef enum logic [4:0] {
    LX_IDLE, LX_AT0, LX_AT1, LX_HASH0, LX_NAME, LX_MINUS0, LX_MINUS1, LX_DOT0, LX_DOT1,
    LX_SLASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR, LX_STRING, LX_INT, LX_INT_NODEC, LX_FRAC
  } lex_mode_e;

  typedef struct {
    kind_t             kind;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic              last;
  } token_t;

  // shadow lexer: follows each accepted request and queues the tokens it must produce
  class token_shadow;
    token_t           due[$];
    token_t           fresh[$];
    lex_mode_e        mode;
    kind_t            p_kind;
    logic [OFF_W-1:0] p_start;
    logic [LEN_W-1:0] p_len;
    char_t            quote;
    logic [OFF_W-1:0] pos;
    int               errors;
    int               checked;
    bit               kind_hit[32];

    function void reset_state();
      mode = LX_IDLE;
      p_kind = KIND_AT;
      p_start = '0;
      p_len = '0;
      quote = '0;
      pos = '0;
    endfunction

    function bit is_lead(char_t c);
      return (c == CH_UNDER) || (c inside {[CH_LA:CH_LZ]}) || (c inside {[CH_UA:CH_UZ]});
    endfunction

    function bit is_dec(char_t c);
      return c inside {[CH_DIG0:CH_DIG9]};
    endfunction

    function bit is_namec(char_t c);
      return is_lead(c) || is_dec(c) || (c == CH_MINUS);
    endfunction

    function void emit(kind_t k, logic [OFF_W-1:0] s, logic [LEN_W-1:0] n);
      token_t t;
      t.kind = k;
      t.offset = s;
      t.length = n;
      t.last = 1'b0;
      fresh.insert(fresh.size(), t);
    endfunction

    function void drop_pending();
      mode = LX_IDLE;
      p_kind = KIND_AT;
      p_start = '0;
      p_len = '0;
    endfunction

    function void close_pending(kind_t k);
      emit(k, p_start, p_len);
      drop_pending();
    endfunction

    // length saturates at all ones
    function void grow_pending();
      if (p_len != '1) p_len = p_len + 1'b1;
    endfunction

    function void start_pending(kind_t k, lex_mode_e m);
      p_kind = k;
      p_start = pos;
      p_len = LEN_ONE;
      mode = m;
    endfunction

    // returns 1 when the pending token swallows the byte
    function bit absorb(char_t c);
      case (mode)
        LX_AT0: begin
          if (c == CH_MINUS) begin grow_pending(); mode = LX_AT1; return 1; end
          if (is_lead(c)) begin grow_pending(); mode = LX_NAME; return 1; end
          close_pending(KIND_OTHER);
          return 0;
        end
        LX_AT1: begin
          if (is_lead(c) || c == CH_MINUS) begin grow_pending(); mode = LX_NAME; return 1; end
          close_pending(KIND_OTHER);
          return 0;
        end
        LX_HASH0: begin
          if (is_namec(c)) begin grow_pending(); mode = LX_NAME; return 1; end
          close_pending(KIND_OTHER);
          return 0;
        end
        LX_NAME: begin
          if (is_namec(c)) begin grow_pending(); return 1; end
          close_pending(p_kind);
          return 0;
        end
        LX_MINUS0: begin
          if (is_dec(c)) begin
            grow_pending(); p_kind = KIND_NUM; mode = LX_INT; return 1;
          end
          if (c == CH_MINUS) begin grow_pending(); mode = LX_MINUS1; return 1; end
          if (is_lead(c)) begin
            grow_pending(); p_kind = KIND_IDENT; mode = LX_NAME; return 1;
          end
          close_pending(KIND_MINUS);
          return 0;
        end
        LX_MINUS1: begin
          if (is_lead(c) || c == CH_MINUS) begin
            grow_pending(); p_kind = KIND_IDENT; mode = LX_NAME; return 1;
          end
          close_pending(KIND_MINUS);
          return 0;
        end
        LX_DOT0: begin
          if (is_dec(c)) begin
            grow_pending(); p_kind = KIND_NUM; mode = LX_INT_NODEC; return 1;
          end
          if (c == CH_MINUS) begin grow_pending(); mode = LX_DOT1; return 1; end
          if (is_lead(c)) begin grow_pending(); mode = LX_NAME; return 1; end
          close_pending(KIND_DOT);
          return 0;
        end
        LX_DOT1: begin
          if (is_lead(c) || c == CH_MINUS) begin grow_pending(); mode = LX_NAME; return 1; end
          close_pending(KIND_OTHER);
          return 0;
        end
        LX_SLASH: begin
          if (c == CH_SLASH) begin mode = LX_LINE; return 1; end
          if (c == CH_STAR) begin
            grow_pending(); p_kind = KIND_COMMENT; mode = LX_BLOCK; return 1;
          end
          close_pending(KIND_DIV);
          return 0;
        end
        // line comment ends silently; the line feed itself is whitespace
        LX_LINE: begin
          if (c == CH_LF) begin drop_pending(); return 0; end
          return 1;
        end
        LX_BLOCK: begin
          grow_pending();
          if (c == CH_STAR) mode = LX_BLOCK_STAR;
          return 1;
        end
        LX_BLOCK_STAR: begin
          grow_pending();
          if (c == CH_SLASH) close_pending(KIND_COMMENT);
          else if (c != CH_STAR) mode = LX_BLOCK;
          return 1;
        end
        LX_STRING: begin
          grow_pending();
          if (c == quote) close_pending(KIND_STRING);
          return 1;
        end
        LX_INT, LX_INT_NODEC, LX_FRAC: begin
          if (is_dec(c)) begin grow_pending(); return 1; end
          if (c == CH_PCT) begin grow_pending(); close_pending(KIND_PCT); return 1; end
          if (c == CH_DOT && mode == LX_INT) begin grow_pending(); mode = LX_FRAC; return 1; end
          close_pending(KIND_NUM);
          return 0;
        end
        default: begin
          mode = LX_IDLE;
          return 0;
        end
      endcase
    endfunction

    function void open_token(char_t c);
      case (c)
        CH_SPACE, CH_TAB, CH_CR, CH_FF, CH_LF: ;
        CH_AT:     start_pending(KIND_AT, LX_AT0);
        CH_HASH:   start_pending(KIND_HASH, LX_HASH0);
        CH_MINUS:  start_pending(KIND_MINUS, LX_MINUS0);
        CH_SLASH:  start_pending(KIND_DIV, LX_SLASH);
        CH_DOT:    start_pending(KIND_DOT, LX_DOT0);
        CH_DQUOTE, CH_SQUOTE: begin
          start_pending(KIND_STRING, LX_STRING);
          quote = c;
        end
        CH_SEMI:   emit(KIND_SEMI, pos, LEN_ONE);
        CH_COLON:  emit(KIND_COLON, pos, LEN_ONE);
        CH_LBRACE: emit(KIND_LBRACE, pos, LEN_ONE);
        CH_RBRACE: emit(KIND_RBRACE, pos, LEN_ONE);
        CH_LPAREN: emit(KIND_LPAREN, pos, LEN_ONE);
        CH_RPAREN: emit(KIND_RPAREN, pos, LEN_ONE);
        CH_LBRACK: emit(KIND_LBRACK, pos, LEN_ONE);
        CH_RBRACK: emit(KIND_RBRACK, pos, LEN_ONE);
        CH_STAR:   emit(KIND_MUL, pos, LEN_ONE);
        CH_PLUS:   emit(KIND_ADD, pos, LEN_ONE);
        default: begin
          if (is_dec(c)) start_pending(KIND_NUM, LX_INT);
          else if (is_lead(c)) start_pending(KIND_IDENT, LX_NAME);
          else emit(KIND_OTHER, pos, LEN_ONE);
        end
      endcase
    endfunction

    // end mark: whatever is pending comes out under its closing kind
    function void flush_pending();
      case (mode)
        LX_IDLE, LX_LINE: ;
        LX_NAME, LX_INT, LX_INT_NODEC, LX_FRAC: close_pending(p_kind);
        LX_MINUS0, LX_MINUS1: close_pending(KIND_MINUS);
        LX_DOT0: close_pending(KIND_DOT);
        LX_SLASH: close_pending(KIND_DIV);
        default: close_pending(KIND_OTHER);
      endcase
    endfunction

    // accepted input request
    function void note_request(char_t c, bit eos);
      fresh.delete();
      if (eos) begin
        flush_pending();
        emit(KIND_END, pos, '0);
        reset_state();
      end else begin
        if (!absorb(c)) open_token(c);
        pos = pos + 1'b1;
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) due.insert(due.size(), fresh[i]);
    endfunction

    // accepted token result
    function void check_token(kind_t k, logic [OFF_W-1:0] off, logic [LEN_W-1:0] n, logic l);
      token_t t;
      checked++;
      kind_hit[k] = 1'b1;
      if (due.size() == 0) begin
        $error("token with none expected: kind %0d offset %0d length %0d", k, off, n);
        errors++;
        return;
      end
      t = due.pop_front();
      if (k !== t.kind) begin
        $error("token_kind: expected %0d, got %0d", t.kind, k);
        errors++;
      end
      if (off !== t.offset) begin
        $error("start_offset: expected %0d, got %0d", t.offset, off);
        errors++;
      end
      if (n !== t.length) begin
        $error("token_length: expected %0d, got %0d", t.length, n);
        errors++;
      end
      if (l !== t.last) begin
        $error("last_of_run: expected %0d, got %0d", t.last, l);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic [4:0] out_tuser;
  logic out_tlast;

  token_shadow shadow = new;
  bit hold_request = 1'b0;
  int sent_bytes = 0;
  int sent_marks = 0;

  localparam char_t PUNCT [10] = '{CH_SEMI, CH_COLON, CH_LBRACE, CH_RBRACE, CH_LPAREN,
                                   CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_STAR, CH_PLUS};

  // bytes of the fragment being built
  char_t frag[$];

  css_token_boundary_lexer #(
    .LENGTH_WIDTH(LEN_W),
    .OFFSET_WIDTH(OFF_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic char_t pick_lead();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return char_t'(CH_LA + r);
    if (r < 52) return char_t'(CH_UA + (r - 26));
    return CH_UNDER;
  endfunction

  function automatic char_t pick_namec();
    int r;
    r = $urandom_range(0, 13);
    if (r < 8) return pick_lead();
    if (r < 12) return char_t'(CH_DIG0 + $urandom_range(0, 9));
    return CH_MINUS;
  endfunction

  function automatic char_t pick_digit();
    return char_t'(CH_DIG0 + $urandom_range(0, 9));
  endfunction

  function automatic void add_byte(char_t b);
    frag.insert(frag.size(), b);
  endfunction

  // one request on the input channel, held until accepted
  task automatic send_byte(char_t c, bit eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= eos;
    do @(posedge clk); while (!in_tready);
    shadow.note_request(c, eos);
    if (eos) sent_marks++;
    else sent_bytes++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_mark();
    send_byte(char_t'($urandom_range(0, 255)), 1'b1);
  endtask

  // one random token-shaped fragment, mostly well formed
  task automatic play_fragment();
    char_t q;
    char_t b;
    int r;
    int n;
    frag.delete();
    r = $urandom_range(0, 19);
    case (r)
      0, 1, 18: begin
        add_byte(pick_lead());
        n = $urandom_range(0, 6);
        repeat (n) add_byte(pick_namec());
      end
      2: begin
        add_byte(CH_AT);
        if ($urandom_range(0, 2) == 0) add_byte(CH_MINUS);
        add_byte($urandom_range(0, 5) == 0 ? CH_MINUS : pick_lead());
        n = $urandom_range(0, 5);
        repeat (n) add_byte(pick_namec());
      end
      3: begin
        add_byte(CH_HASH);
        n = $urandom_range(1, 5);
        repeat (n) add_byte(pick_namec());
      end
      4, 5, 19: begin
        n = $urandom_range(1, 4);
        repeat (n) add_byte(pick_digit());
        if ($urandom_range(0, 2) == 0) begin
          add_byte(CH_DOT);
          n = $urandom_range(0, 3);
          repeat (n) add_byte(pick_digit());
        end
        if ($urandom_range(0, 2) == 0) add_byte(CH_PCT);
      end
      6: begin
        n = $urandom_range(0, 3);
        add_byte(n == 0 ? CH_MINUS : CH_DOT);
        if (n == 1) add_byte(pick_lead());
        else if (n == 2) add_byte(CH_MINUS);
        else add_byte(pick_digit());
        n = $urandom_range(0, 3);
        repeat (n) add_byte(r[0] ? pick_digit() : pick_namec());
        if ($urandom_range(0, 3) == 0) add_byte(CH_PCT);
      end
      7: begin
        add_byte(CH_MINUS);
        if ($urandom_range(0, 1)) add_byte(CH_MINUS);
        if ($urandom_range(0, 1)) add_byte(pick_namec());
      end
      8: begin
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        add_byte(q);
        n = $urandom_range(0, 6);
        repeat (n) begin
          b = char_t'($urandom_range(0, 255));
          add_byte(b == q ? CH_SPACE : b);
        end
        if ($urandom_range(0, 7) != 0) add_byte(q);
      end
      9: begin
        add_byte(CH_SLASH);
        add_byte(CH_STAR);
        n = $urandom_range(0, 8);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: add_byte(CH_STAR);
            1: add_byte(CH_SLASH);
            2: add_byte(pick_lead());
            default: add_byte(char_t'($urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 7) != 0) begin
          add_byte(CH_STAR);
          add_byte(CH_SLASH);
        end
      end
      10: begin
        add_byte(CH_SLASH);
        add_byte(CH_SLASH);
        n = $urandom_range(0, 6);
        repeat (n) begin
          b = char_t'($urandom_range(0, 255));
          add_byte(b == CH_LF ? CH_STAR : b);
        end
        add_byte(CH_LF);
      end
      11, 12: add_byte(PUNCT[$urandom_range(0, 9)]);
      13, 14: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: add_byte(CH_TAB);
            1: add_byte(CH_CR);
            2: add_byte(CH_FF);
            3: add_byte(CH_LF);
            default: add_byte(CH_SPACE);
          endcase
        end
      end
      15: add_byte(char_t'($urandom_range(0, 255)));
      16: begin
        // broken starts
        case ($urandom_range(0, 4))
          0: add_byte(CH_AT);
          1: begin add_byte(CH_AT); add_byte(CH_MINUS); end
          2: add_byte(CH_HASH);
          3: begin add_byte(CH_DOT); add_byte(CH_MINUS); end
          default: add_byte(CH_SLASH);
        endcase
        add_byte($urandom_range(0, 1) ? CH_SPACE : PUNCT[$urandom_range(0, 9)]);
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          case ($urandom_range(0, 6))
            0: add_byte(CH_DOT);
            1: add_byte(CH_MINUS);
            2: add_byte(CH_SLASH);
            3: add_byte(CH_STAR);
            4: add_byte(CH_PCT);
            5: add_byte(pick_digit());
            default: add_byte(pick_lead());
          endcase
        end
      end
    endcase
    foreach (frag[i]) send_byte(frag[i], 1'b0);
    if ($urandom_range(0, 2) == 0) send_byte(CH_SPACE, 1'b0);
    if ($urandom_range(0, 39) == 0) send_mark();
  endtask

  // result side: random ready, long holds on request
  initial begin
    int r;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end else begin
          out_tready <= 1'b0;
          repeat (r == 9 ? $urandom_range(8, 30) : $urandom_range(1, 3)) @(posedge clk);
        end
      end
    end
  end

  // token monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      shadow.check_token(out_tuser, out_tdata[OFF_W-1:0], out_tdata[OFF_W+LEN_W-1:OFF_W],
                         out_tlast);
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb_css_token_boundary_lexer: done, errors");
    $finish;
  end

  // main sequence
  initial begin
    int kinds;
    int start_bytes;
    shadow.reset_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every kind, broken starts, line comment, extreme bytes
    send_text("@-x{#9}(5.2%);:[.a]*+-3--y//c");
    send_byte(CH_LF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("'s\"'.5 @ # .-;@-;-- . / /*a**/");
    send_byte(CH_TAB, 1'b0);
    send_mark();
    // unterminated string and comment, flush of a pending number, bare end mark
    send_text("\"op");
    send_mark();
    send_text("/*x");
    send_mark();
    send_text("7");
    send_mark();
    send_mark();

    // random token-shaped traffic, with long holds on the result side
    start_bytes = sent_bytes;
    while (sent_bytes - start_bytes < 320) begin
      if (sent_bytes - start_bytes > 60 && sent_bytes - start_bytes < 70) hold_request = 1'b1;
      play_fragment();
    end
    send_mark();
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;

    while (shadow.due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    kinds = 0;
    foreach (shadow.kind_hit[i]) kinds += shadow.kind_hit[i];
    $display("lexed %0d bytes over %0d end marks; %0d tokens checked, %0d token kinds seen",
             sent_bytes, sent_marks, shadow.checked, kinds);
    if (shadow.errors == 0 && shadow.due.size() == 0) begin
      $display("tb_css_token_boundary_lexer: done, clean");
    end else begin
      $display("tb_css_token_boundary_lexer: done, errors");
    end
    $finish;
  end

endmodule

/* css_token_boundary_lexer.f */
+incdir+rtl
rtl/csstok_pkg.sv
rtl/css_token_boundary_lexer.sv
sim/tb_css_token_boundary_lexer.sv
